// ===== rtl/core/aabb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared codes, widths and controller/datapath interface types for the
// box collider table.
// ----------------------------------------------------------------------------
package aabb_pkg;

	localparam int MAX_BOXES_DEF  = 64;
	localparam int COORD_BITS_DEF = 16;

	localparam int FUNC_W   = 3;
	localparam int SLOT_W   = 6;
	localparam int SIZE_W   = 15;
	localparam int STATUS_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_CREATE = 3'd0,
		FN_DELETE = 3'd1,
		FN_MOVE   = 3'd2,
		FN_BOX    = 3'd3,
		FN_POINT  = 3'd4
	} func_t;

	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NOUSE = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic latch;       // capture the command fields, clear results
		logic cnt_inc;     // advance the entry counter
		logic scan_rd;     // read the entry at the counter into the compare stage
		logic self_rd;     // read the addressed entry
		logic self_cap;    // keep the addressed entry as the query box
		logic wr_create;   // fill the entry at the counter
		logic wr_move;     // write the position of the addressed entry
		logic wr_delete;   // free the addressed entry
		logic set_created; // report the counter as the new slot
		logic set_full;
		logic set_nouse;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              in_use;
		logic              cur_free;
		logic              cnt_last;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/aabb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_ctrl
// Sequencer for the collider table: decodes the command and steps the
// datapath through create search, writes and query scans.
// ----------------------------------------------------------------------------
module aabb_ctrl import aabb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECODE = 7'b0000010,
		ST_CREATE = 7'b0000100,
		ST_SELF   = 7'b0001000,
		ST_SCAN   = 7'b0010000,
		ST_DRAIN  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_DONE;
				case (sts.func)
					FN_CREATE: state_d = ST_CREATE;
					FN_DELETE: begin
						cmd.wr_delete = sts.in_use;
						cmd.set_nouse = !sts.in_use;
					end
					FN_MOVE: begin
						cmd.wr_move   = sts.in_use;
						cmd.set_nouse = !sts.in_use;
					end
					FN_BOX: begin
						if (sts.in_use) begin
							cmd.self_rd = 1'b1;
							state_d     = ST_SELF;
						end else begin
							cmd.set_nouse = 1'b1;
						end
					end
					FN_POINT: state_d = ST_SCAN;
					default: state_d = ST_DONE;
				endcase
			end
			ST_CREATE: begin
				if (sts.cur_free) begin
					cmd.wr_create   = 1'b1;
					cmd.set_created = 1'b1;
					state_d         = ST_DONE;
				end else if (sts.cnt_last) begin
					cmd.set_full = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_SELF: begin
				cmd.self_cap = 1'b1;
				state_d      = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

`default_nettype wire

// ===== rtl/core/aabb_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_dp
// Collider table storage and compare datapath: valid bits, position and
// size memories, entry counter, one registered compare stage, result regs.
// ----------------------------------------------------------------------------
module aabb_dp import aabb_pkg::*; #(
	parameter int MAX_BOXES  = MAX_BOXES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cmd_t                         cmd,
	output sts_t                              sts,
	input  wire logic        [FUNC_W-1:0]     func,
	input  wire logic        [SLOT_W-1:0]     slot,
	input  wire logic signed [COORD_BITS-1:0] coord_x,
	input  wire logic signed [COORD_BITS-1:0] coord_y,
	input  wire logic        [SIZE_W-1:0]     box_w,
	input  wire logic        [SIZE_W-1:0]     box_h,
	output logic             [SLOT_W-1:0]     slot_out,
	output logic                              hit,
	output logic             [STATUS_W-1:0]   status
);

	localparam int IDX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int WIDE_W = IDX_W + SLOT_W;
	localparam int SUM_W  = ((COORD_BITS > SIZE_W + 1) ? COORD_BITS : SIZE_W + 1) + 1;
	localparam int POS_W  = 2 * COORD_BITS;
	localparam int DIM_W  = 2 * SIZE_W;

	// latched command
	logic        [FUNC_W-1:0]     func_q;
	logic        [SLOT_W-1:0]     slot_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic        [SIZE_W-1:0]     bw_q, bh_q;

	logic [IDX_W-1:0] cnt_q;
	logic [MAX_BOXES-1:0] valid_q;

	logic [POS_W-1:0] pos_mem [MAX_BOXES];
	logic [DIM_W-1:0] dim_mem [MAX_BOXES];
	logic [POS_W-1:0] pos_rd_q;
	logic [DIM_W-1:0] dim_rd_q;

	logic [WIDE_W-1:0] slot_wide, cnt_wide;
	logic [IDX_W-1:0]  slot_idx, rd_addr;
	logic              in_range;

	assign slot_wide = {{IDX_W{1'b0}}, slot_q};
	assign cnt_wide  = {{SLOT_W{1'b0}}, cnt_q};
	assign in_range  = slot_wide < WIDE_W'(MAX_BOXES);
	assign slot_idx  = slot_wide[IDX_W-1:0];
	assign rd_addr   = cmd.self_rd ? slot_idx : cnt_q;

	assign sts.func     = func_q;
	assign sts.in_use   = in_range && valid_q[slot_idx];
	assign sts.cur_free = !valid_q[cnt_q];
	assign sts.cnt_last = (cnt_q == IDX_W'(MAX_BOXES - 1));

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			slot_q <= slot;
			cx_q   <= coord_x;
			cy_q   <= coord_y;
			bw_q   <= box_w;
			bh_q   <= box_h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.latch) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_create) begin
			valid_q[cnt_q] <= 1'b1;
		end else if (cmd.wr_delete) begin
			valid_q[slot_idx] <= 1'b0;
		end
	end

	// table memories: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_create) begin
			pos_mem[cnt_q] <= '0;
		end else if (cmd.wr_move) begin
			pos_mem[slot_idx] <= {cx_q, cy_q};
		end
		if (cmd.wr_create) begin
			dim_mem[cnt_q] <= {bw_q, bh_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.self_rd || cmd.scan_rd) begin
			pos_rd_q <= pos_mem[rd_addr];
			dim_rd_q <= dim_mem[rd_addr];
		end
	end

	// entry just read, unpacked and widened
	logic signed [COORD_BITS-1:0] xj, yj;
	logic        [SIZE_W-1:0]     wj, hj;
	logic signed [SUM_W-1:0]      xj_e, yj_e, xj_r, yj_t;

	assign xj   = pos_rd_q[POS_W-1:COORD_BITS];
	assign yj   = pos_rd_q[COORD_BITS-1:0];
	assign wj   = dim_rd_q[DIM_W-1:SIZE_W];
	assign hj   = dim_rd_q[SIZE_W-1:0];
	assign xj_e = SUM_W'(xj);
	assign yj_e = SUM_W'(yj);
	assign xj_r = xj_e + SUM_W'(wj);
	assign yj_t = yj_e + SUM_W'(hj);

	// query box, held during the scan
	logic signed [SUM_W-1:0] sx_q, sy_q, sxr_q, syt_q;

	always_ff @(posedge clk) begin
		if (cmd.self_cap) begin
			sx_q  <= xj_e;
			sy_q  <= yj_e;
			sxr_q <= xj_r;
			syt_q <= yj_t;
		end
	end

	// compare stage tags, aligned with the read data
	logic             valid_s1, en_s1;
	logic [IDX_W-1:0] idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			en_s1  <= valid_q[cnt_q];
			idx_s1 <= cnt_q;
		end
	end

	logic signed [SUM_W-1:0] px, py;
	logic overlap, contain, match;

	assign px = SUM_W'(cx_q);
	assign py = SUM_W'(cy_q);

	assign overlap = (sx_q < xj_r) && (sxr_q > xj_e) && (sy_q < yj_t) && (syt_q > yj_e);
	assign contain = (px >= xj_e) && (py >= yj_e) && (px < xj_r) && (py < yj_t);
	assign match   = (func_q == FN_POINT) ? contain : (overlap && (idx_s1 != slot_idx));

	logic [SLOT_W-1:0]   slot_out_q;
	logic                hit_q;
	logic [STATUS_W-1:0] status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_out_q <= '0;
			hit_q      <= 1'b0;
			status_q   <= STS_OK;
		end else begin
			if (cmd.latch) begin
				slot_out_q <= slot;
				hit_q      <= 1'b0;
				status_q   <= STS_OK;
			end else begin
				if (cmd.set_created) begin
					slot_out_q <= cnt_wide[SLOT_W-1:0];
				end else if (cmd.set_full) begin
					slot_out_q <= '0;
					status_q   <= STS_FULL;
				end else if (cmd.set_nouse) begin
					status_q <= STS_NOUSE;
				end
				if (valid_s1 && en_s1 && match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	assign slot_out = slot_out_q;
	assign hit      = hit_q;
	assign status   = status_q;

endmodule

`default_nettype wire

// ===== rtl/core/aabb_collider_table_unit.sv =====
`default_nettype none
// Create tests one valid bit per cycle, lowest first; point and box queries make
// one memory read per entry. One command at a time: start is taken again the
// cycle after done. Results are held until the next command is accepted: done
// marks one cycle. Reset empties the table at once; entry contents are not
// cleared.
// ----------------------------------------------------------------------------
// aabb_collider_table_unit
// Table of axis-aligned boxes with create, delete, move, box overlap query
// and point containment query.
// ----------------------------------------------------------------------------
module aabb_collider_table_unit import aabb_pkg::*; #(
	parameter int MAX_BOXES  = MAX_BOXES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic        [FUNC_W-1:0]     func,
	input  wire logic        [SLOT_W-1:0]     slot,
	input  wire logic signed [COORD_BITS-1:0] coord_x,
	input  wire logic signed [COORD_BITS-1:0] coord_y,
	input  wire logic        [SIZE_W-1:0]     box_w,
	input  wire logic        [SIZE_W-1:0]     box_h,
	output logic                              done,
	output logic             [SLOT_W-1:0]     slot_out,
	output logic                              hit,
	output logic             [STATUS_W-1:0]   status
);

	cmd_t cmd;
	sts_t sts;

	aabb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	aabb_dp #(
		.MAX_BOXES  (MAX_BOXES),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.func     (func),
		.slot     (slot),
		.coord_x  (coord_x),
		.coord_y  (coord_y),
		.box_w    (box_w),
		.box_h    (box_h),
		.slot_out (slot_out),
		.hit      (hit),
		.status   (status)
	);

endmodule

`default_nettype wire

// ===== verif/aabb_table_checker.sv =====
// ----------------------------------------------------------------------------
// aabb_table_checker
// Watches the command and result channels of the box collider table. It keeps
// its own copy of the box table, works out the result of every accepted
// command and compares each done strobe with the oldest expected result.
// ----------------------------------------------------------------------------
module aabb_table_checker import aabb_pkg::*; #(
	parameter int MAX_BOXES  = MAX_BOXES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic        [FUNC_W-1:0]     func,
	input  logic        [SLOT_W-1:0]     slot,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic        [SIZE_W-1:0]     box_w,
	input  logic        [SIZE_W-1:0]     box_h,
	input  logic                         done,
	input  logic        [SLOT_W-1:0]     slot_out,
	input  logic                         hit,
	input  logic        [STATUS_W-1:0]   status,
	output int                           err_count,
	output int                           open_cnt,
	output int                           checked_cnt,
	output int                           hit_cnt,
	output int                           full_cnt
);

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic                hit;
		logic [STATUS_W-1:0] status;
	} table_result_t;

	bit                         occupied [MAX_BOXES];
	logic signed [COORD_BITS-1:0] x_tab  [MAX_BOXES];
	logic signed [COORD_BITS-1:0] y_tab  [MAX_BOXES];
	logic        [SIZE_W-1:0]     w_tab  [MAX_BOXES];
	logic        [SIZE_W-1:0]     h_tab  [MAX_BOXES];

	table_result_t result_q[$];

	// Apply one command to the table copy and return its result.
	function automatic table_result_t run_command(
		logic        [FUNC_W-1:0]     f,
		logic        [SLOT_W-1:0]     s,
		logic signed [COORD_BITS-1:0] cx,
		logic signed [COORD_BITS-1:0] cy,
		logic        [SIZE_W-1:0]     bw,
		logic        [SIZE_W-1:0]     bh
	);
		table_result_t r;
		bit            slot_live;
		longint        sx, sy, sw, sh, jx, jy, jw, jh, px, py;
		int            j;
		r.slot   = s;
		r.hit    = 1'b0;
		r.status = STS_OK;
		slot_live = (int'(s) < MAX_BOXES) && occupied[s];
		px = longint'(cx);
		py = longint'(cy);
		case (f)
			FN_CREATE: begin
				r.status = STS_FULL;
				r.slot   = '0;
				for (j = 0; j < MAX_BOXES; j++) begin
					if (!occupied[j]) begin
						occupied[j] = 1'b1;
						x_tab[j]    = '0;
						y_tab[j]    = '0;
						w_tab[j]    = bw;
						h_tab[j]    = bh;
						r.slot      = j[SLOT_W-1:0];
						r.status    = STS_OK;
						break;
					end
				end
			end
			FN_DELETE, FN_MOVE, FN_BOX: begin
				if (!slot_live) begin
					r.status = STS_NOUSE;
				end else if (f == FN_DELETE) begin
					occupied[s] = 1'b0;
				end else if (f == FN_MOVE) begin
					x_tab[s] = cx;
					y_tab[s] = cy;
				end else begin
					sx = longint'(x_tab[s]);
					sy = longint'(y_tab[s]);
					sw = longint'(w_tab[s]);
					sh = longint'(h_tab[s]);
					for (j = 0; j < MAX_BOXES; j++) begin
						if (j == int'(s) || !occupied[j])
							continue;
						jx = longint'(x_tab[j]);
						jy = longint'(y_tab[j]);
						jw = longint'(w_tab[j]);
						jh = longint'(h_tab[j]);
						// strict overlap: touching edges do not count
						if (sx < jx + jw && sx + sw > jx && sy < jy + jh && sy + sh > jy) begin
							r.hit = 1'b1;
							break;
						end
					end
				end
			end
			FN_POINT: begin
				for (j = 0; j < MAX_BOXES; j++) begin
					if (!occupied[j])
						continue;
					jx = longint'(x_tab[j]);
					jy = longint'(y_tab[j]);
					jw = longint'(w_tab[j]);
					jh = longint'(h_tab[j]);
					// half-open: low edge inside, high edge outside
					if (px >= jx && py >= jy && px < jx + jw && py < jy + jh) begin
						r.hit = 1'b1;
						break;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
			$realtime, checked_cnt, what, got, want);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		table_result_t want;
		int            j;
		if (!arst_n) begin
			for (j = 0; j < MAX_BOXES; j++)
				occupied[j] = 1'b0;
			result_q.delete();
			err_count   = 0;
			open_cnt    = 0;
			checked_cnt = 0;
			hit_cnt     = 0;
			full_cnt    = 0;
		end else begin
			// compare the finishing result before taking a new command
			if (done) begin
				if (result_q.size() == 0) begin
					report_mismatch("done with no command outstanding, slot_out",
						slot_out, 0);
				end else begin
					want = result_q.pop_front();
					if (slot_out !== want.slot)
						report_mismatch("slot_out", slot_out, want.slot);
					if (hit !== want.hit)
						report_mismatch("hit", hit, want.hit);
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (want.hit)
						hit_cnt++;
					if (want.status == STS_FULL)
						full_cnt++;
				end
				checked_cnt++;
			end
			if (start && !busy)
				result_q.insert(result_q.size(),
					run_command(func, slot, coord_x, coord_y, box_w, box_h));
			open_cnt = result_q.size();
		end
	end

endmodule

// ===== verif/tb_aabb_collider_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_aabb_collider_table_unit
// Drives the box collider table with a short directed sequence and about a
// thousand random commands, in fill, mixed and drain mixes under several
// sender idle rates; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_aabb_collider_table_unit;
	import aabb_pkg::*;

	localparam int MAX_BOXES   = MAX_BOXES_DEF;
	localparam int COORD_BITS  = COORD_BITS_DEF;
	localparam int QUIET_LIMIT = 5000;
	localparam int TAIL_CYCLES = MAX_BOXES + 16;
	localparam int BLOCKS      = 9;
	localparam int BLOCK_ITEMS = 112;

	// reserved function codes, no operation
	localparam logic [FUNC_W-1:0] FN_RSVD_LO = 3'd5;

	typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} op_mix_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic        [FUNC_W-1:0]     func;
	logic        [SLOT_W-1:0]     slot;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic        [SIZE_W-1:0]     box_w;
	logic        [SIZE_W-1:0]     box_h;
	logic                         done;
	logic        [SLOT_W-1:0]     slot_out;
	logic                         hit;
	logic        [STATUS_W-1:0]   status;

	int err_count, open_cnt, checked_cnt, hit_cnt, full_cnt;
	int quiet_cycles;
	int func_seen [8];
	bit [MAX_BOXES-1:0] live_hint;   // slots believed in use, steers stimulus only

	aabb_collider_table_unit #(
		.MAX_BOXES (MAX_BOXES),
		.COORD_BITS(COORD_BITS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.func    (func),
		.slot    (slot),
		.coord_x (coord_x),
		.coord_y (coord_y),
		.box_w   (box_w),
		.box_h   (box_h),
		.done    (done),
		.slot_out(slot_out),
		.hit     (hit),
		.status  (status)
	);

	aabb_table_checker #(
		.MAX_BOXES (MAX_BOXES),
		.COORD_BITS(COORD_BITS)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.slot       (slot),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.box_w      (box_w),
		.box_h      (box_h),
		.done       (done),
		.slot_out   (slot_out),
		.hit        (hit),
		.status     (status),
		.err_count  (err_count),
		.open_cnt   (open_cnt),
		.checked_cnt(checked_cnt),
		.hit_cnt    (hit_cnt),
		.full_cnt   (full_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// end the run when no transfer happens for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results open",
					QUIET_LIMIT, open_cnt);
				$display("FAIL aabb_collider_table_unit");
				$finish;
			end
		end
	end

	// Present one command at a falling edge and hold it until the transfer.
	task automatic send_cmd(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] s,
		logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
		logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
		int k;
		start   <= 1'b1;
		func    <= f;
		slot    <= s;
		coord_x <= x;
		coord_y <= y;
		box_w   <= w;
		box_h   <= h;
		// busy only moves on a rising edge, so it is stable here
		while (busy)
			@(negedge clk);
		@(negedge clk);
		func_seen[f]++;
		if (f == FN_CREATE) begin
			for (k = 0; k < MAX_BOXES; k++) begin
				if (!live_hint[k]) begin
					live_hint[k] = 1'b1;
					break;
				end
			end
		end else if (f == FN_DELETE && int'(s) < MAX_BOXES) begin
			live_hint[s] = 1'b0;
		end
	endtask

	// Drop start and hold off until every outstanding result has come back.
	task automatic wait_drained();
		start <= 1'b0;
		while (open_cnt != 0)
			@(negedge clk);
	endtask

	function automatic logic [SLOT_W-1:0] pick_slot();
		int base, k, idx;
		if (live_hint != '0 && $urandom_range(99) < 85) begin
			base = $urandom_range(MAX_BOXES - 1);
			for (k = 0; k < MAX_BOXES; k++) begin
				idx = (base + k) % MAX_BOXES;
				if (live_hint[idx])
					return idx[SLOT_W-1:0];
			end
		end
		return SLOT_W'($urandom_range(63));
	endfunction

	function automatic logic [COORD_BITS-1:0] rand_coord();
		int r, v;
		r = $urandom_range(99);
		if (r < 70) begin
			v = int'($urandom_range(1023)) - 512;
			return v[COORD_BITS-1:0];
		end else if (r < 76) begin
			return $urandom_range(1) ? {1'b0, {(COORD_BITS-1){1'b1}}}
				: {1'b1, {(COORD_BITS-1){1'b0}}};
		end
		return COORD_BITS'($urandom());
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return SIZE_W'($urandom_range(600));
		else if (r < 80)
			return $urandom_range(1) ? '0 : '1;
		return SIZE_W'($urandom());
	endfunction

	task automatic random_cmd(op_mix_t mix);
		int cut_create, cut_delete, cut_move, cut_box, cut_point, r;
		logic [FUNC_W-1:0] f;
		case (mix)
			MIX_FILL: begin
				cut_create = 45; cut_delete = 50; cut_move = 65; cut_box = 80; cut_point = 97;
			end
			MIX_DRAIN: begin
				cut_create = 5; cut_delete = 50; cut_move = 65; cut_box = 80; cut_point = 97;
			end
			default: begin
				cut_create = 20; cut_delete = 38; cut_move = 58; cut_box = 78; cut_point = 98;
			end
		endcase
		r = $urandom_range(99);
		if (r < cut_create)
			f = FN_CREATE;
		else if (r < cut_delete)
			f = FN_DELETE;
		else if (r < cut_move)
			f = FN_MOVE;
		else if (r < cut_box)
			f = FN_BOX;
		else if (r < cut_point)
			f = FN_POINT;
		else
			f = FN_RSVD_LO + FUNC_W'($urandom_range(2));
		send_cmd(f, pick_slot(), rand_coord(), rand_coord(), rand_size(), rand_size());
	endtask

	initial begin
		int idle_pct [3];
		int b, n, idle;
		op_mix_t mix;
		idle_pct[0] = 0;
		idle_pct[1] = 57;
		idle_pct[2] = 6;
		live_hint = '0;
		arst_n  = 1'b0;
		start   = 1'b0;
		func    = FN_CREATE;
		slot    = '0;
		coord_x = '0;
		coord_y = '0;
		box_w   = '0;
		box_h   = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, unused slots, extreme sizes and corners
		send_cmd(FN_POINT,  6'd0,  16'h0000, 16'h0000, 15'd0, 15'd0);
		send_cmd(FN_BOX,    6'd0,  16'h0000, 16'h0000, 15'd0, 15'd0);
		send_cmd(FN_DELETE, 6'd63, 16'h0000, 16'h0000, 15'd0, 15'd0);
		send_cmd(FN_MOVE,   6'd5,  16'h7fff, 16'h8000, 15'h7fff, 15'h7fff);
		send_cmd(FN_CREATE, 6'd63, 16'hffff, 16'hffff, 15'd0, 15'd0);
		send_cmd(FN_CREATE, 6'd0,  16'h0000, 16'h0000, 15'h7fff, 15'h7fff);
		send_cmd(FN_CREATE, 6'd0,  16'h0000, 16'h0000, 15'd16, 15'd16);
		send_cmd(FN_CREATE, 6'd0,  16'h0000, 16'h0000, 15'd16, 15'd16);
		send_cmd(FN_MOVE,   6'd1,  16'h8000, 16'h8000, 15'd0, 15'd0);
		send_cmd(FN_MOVE,   6'd2,  16'h7fff, 16'h7fff, 15'd0, 15'd0);
		send_cmd(FN_MOVE,   6'd3,  16'hfff0, 16'hfff0, 15'd0, 15'd0);
		send_cmd(FN_BOX,    6'd1,  16'h0000, 16'h0000, 15'd0, 15'd0);
		send_cmd(FN_BOX,    6'd0,  16'h0000, 16'h0000, 15'd0, 15'd0);
		send_cmd(FN_BOX,    6'd2,  16'h0000, 16'h0000, 15'd0, 15'd0);
		send_cmd(FN_POINT,  6'd7,  16'hffff, 16'hffff, 15'd0, 15'd0);
		send_cmd(FN_POINT,  6'd0,  16'h0000, 16'h0000, 15'd0, 15'd0);
		send_cmd(FN_POINT,  6'd0,  16'h7fff, 16'h7fff, 15'd0, 15'd0);
		send_cmd(FN_POINT,  6'd0,  16'h8000, 16'h8000, 15'd0, 15'd0);
		send_cmd(FN_RSVD_LO,        6'd63, 16'h1234, 16'h8765, 15'd1, 15'd1);
		send_cmd(FN_RSVD_LO + 3'd1, 6'd63, 16'h0000, 16'h0000, 15'd0, 15'd0);
		send_cmd(FN_RSVD_LO + 3'd2, 6'd42, 16'hffff, 16'hffff, 15'h7fff, 15'h7fff);
		send_cmd(FN_DELETE, 6'd1,  16'h0000, 16'h0000, 15'd0, 15'd0);
		send_cmd(FN_BOX,    6'd1,  16'h0000, 16'h0000, 15'd0, 15'd0);
		send_cmd(FN_CREATE, 6'd0,  16'h0000, 16'h0000, 15'd1, 15'd1);
		send_cmd(FN_DELETE, 6'd0,  16'h0000, 16'h0000, 15'd0, 15'd0);
		wait_drained();
		@(negedge clk);

		// random: every pairing of operation mix and sender idle rate
		for (b = 0; b < BLOCKS; b++) begin
			mix  = op_mix_t'(b % 3);
			idle = idle_pct[(b / 3) % 3];
			for (n = 0; n < BLOCK_ITEMS; n++) begin
				random_cmd(mix);
				if ($urandom_range(99) < idle) begin
					start <= 1'b0;
					repeat ($urandom_range(1, MAX_BOXES + 12)) @(negedge clk);
				end
			end
			wait_drained();
			@(negedge clk);
		end

		start <= 1'b0;
		while (open_cnt != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d commands: create %0d, delete %0d, move %0d, box %0d,",
			func_seen.sum(), func_seen[FN_CREATE], func_seen[FN_DELETE], func_seen[FN_MOVE],
			func_seen[FN_BOX]);
		$display("point %0d, reserved %0d; %0d results checked, %0d hits, %0d full, %0d bad",
			func_seen[FN_POINT],
			func_seen[FN_RSVD_LO] + func_seen[FN_RSVD_LO + 1] + func_seen[FN_RSVD_LO + 2],
			checked_cnt, hit_cnt, full_cnt, err_count);
		if (err_count == 0)
			$display("PASS aabb_collider_table_unit");
		else
			$display("FAIL aabb_collider_table_unit");
		$finish;
	end

endmodule
